### hdl/sqs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad setup package
// Shared types, register codes and constants of the sprite quad setup unit.
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int COORD_W     = 24;
  localparam int DELAY_W     = 16;
  localparam int TILE_REG_W  = 7;
  localparam int UV_W        = 16;
  localparam int PHASE_W     = 24;
  localparam int ROT_STEPS   = 20;
  localparam int ROT_IDX_W   = 5;
  localparam int ROT_W       = 33;
  localparam int Z_W         = 25;
  localparam int PROD_W      = 58;
  localparam int SUM_W       = 60;

  localparam logic signed [ROT_W-1:0] ROT_GAIN = 33'sd652032874;
  localparam logic [UV_W-1:0]         UV_ONE   = 16'd32768;
  localparam logic [1:0]              LAST_CORNER_INDEX = 2'd3;

  localparam logic [21:0] ROT_TABLE [ROT_STEPS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669,
    22'd83416, 22'd41718, 22'd20860, 22'd10430, 22'd5215,
    22'd2608, 22'd1304, 22'd652, 22'd326, 22'd163,
    22'd81, 22'd41, 22'd20, 22'd10, 22'd5
  };

  typedef enum logic [1:0] {
    CFG_TILE_COLUMNS = 2'd0,
    CFG_TILE_ROWS    = 2'd1,
    CFG_FRAME_DELAY  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_QUAD = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ITER,
    BK_MUL,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [1:0]         reg_index;
    logic [DELAY_W-1:0] wdata;
  } cfg_req_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        quad_width;
    logic [COORD_W-1:0]        quad_height;
    logic [ANGLE_BITS-1:0]     angle;
  } quad_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        quad_width;
    logic [COORD_W-1:0]        quad_height;
    logic [ANGLE_BITS-1:0]     angle;
  } geom_t;

  typedef struct packed {
    logic [1:0]                corner_index;
    logic signed [COORD_W-1:0] corner_x;
    logic signed [COORD_W-1:0] corner_y;
    logic [UV_W-1:0]           tex_u;
    logic [UV_W-1:0]           tex_v;
    logic                      last_corner;
  } corner_rsp_t;

endpackage

### hdl/sqs_stream_if.sv
// ----------------------------------------------------------------------------
// Sprite quad setup stream interface
// Valid/ready channel carrying one request or result per handshake.
// ----------------------------------------------------------------------------
interface sqs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/sprite_quad_setup_unit.sv
// ----------------------------------------------------------------------------
// Sprite quad setup unit
// Steps sprite-sheet animation and turns quad requests into four corners.
// ----------------------------------------------------------------------------
// A tick request advances the tick counter and steps the animation frame once the
// frame delay is reached. A quad request is queued in a two-entry job queue and
// then worked on by the back end: the tile UV dividers retire one quotient bit per
// cycle, the 20-step rotation runs alongside, one shared multiplier forms four
// products, and the four corners leave one per cycle through an output register
// while the output is not stalled. Ticks keep being taken while a quad is being
// worked on, unless the queue is full.
module sprite_quad_setup_unit #(
  parameter int MAX_TILES_PER_AXIS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sqs_stream_if.sink   cfg_req_i,
  sqs_stream_if.sink   quad_req_i,
  sqs_stream_if.source corner_rsp_o
);

  localparam int CW = $clog2(MAX_TILES_PER_AXIS);
  localparam int TW = $clog2(MAX_TILES_PER_AXIS + 1);
  localparam int JW = $bits(sqs_pkg::geom_t) + 2 * CW + 2 * TW;

  sqs_pkg::geom_t geom_in, geom_out;
  logic [CW-1:0]  col_in, row_in, col_out, row_out;
  logic [TW-1:0]  cols_in, rows_in, cols_out, rows_out;
  logic [JW-1:0]  job_in, job_out;
  logic           push, full, pop, job_valid;

  sqs_front #(
    .MAX_TILES_PER_AXIS(MAX_TILES_PER_AXIS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_req_i (cfg_req_i),
    .quad_req_i(quad_req_i),
    .full_i    (full),
    .push_o    (push),
    .geom_o    (geom_in),
    .col_o     (col_in),
    .row_o     (row_in),
    .cols_o    (cols_in),
    .rows_o    (rows_in)
  );

  assign job_in = {geom_in, col_in, row_in, cols_in, rows_in};

  sqs_queue #(
    .W(JW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(job_in),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .pop_data_o (job_out)
  );

  assign {geom_out, col_out, row_out, cols_out, rows_out} = job_out;

  sqs_back #(
    .MAX_TILES_PER_AXIS(MAX_TILES_PER_AXIS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_geom_i (geom_out),
    .job_col_i  (col_out),
    .job_row_i  (row_out),
    .job_cols_i (cols_out),
    .job_rows_i (rows_out),
    .job_pop_o  (pop),
    .out_valid_o(corner_rsp_o.valid),
    .out_data_o (corner_rsp_o.data),
    .out_ready_i(corner_rsp_o.ready)
  );

endmodule

### hdl/sqs_queue.sv
// ----------------------------------------------------------------------------
// Sprite quad setup job queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
module sqs_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/sqs_front.sv
// ----------------------------------------------------------------------------
// Sprite quad setup front end
// Holds the registers and animation state, runs ticks and queues quad jobs.
// ----------------------------------------------------------------------------
module sqs_front #(
  parameter int MAX_TILES_PER_AXIS = 64,
  parameter int CW = $clog2(MAX_TILES_PER_AXIS),
  parameter int TW = $clog2(MAX_TILES_PER_AXIS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sqs_stream_if.sink    cfg_req_i,
  sqs_stream_if.sink    quad_req_i,
  input  logic          full_i,
  output logic          push_o,
  output sqs_pkg::geom_t geom_o,
  output logic [CW-1:0] col_o,
  output logic [CW-1:0] row_o,
  output logic [TW-1:0] cols_o,
  output logic [TW-1:0] rows_o
);

  logic [sqs_pkg::TILE_REG_W-1:0] cols_reg_q, rows_reg_q;
  logic [sqs_pkg::DELAY_W-1:0]    delay_q, tick_q, tick_d, delay_eff;
  logic [CW-1:0]                  col_q, col_d, row_q, row_d;
  logic [sqs_pkg::DELAY_W:0]      next_cnt;
  logic [CW:0]                    col_inc, row_inc, cols_x, rows_x;
  logic [TW-1:0]                  cols_eff, rows_eff;
  logic                           accept, cfg_write, tick;

  assign cfg_req_i.ready  = 1'b1;
  assign quad_req_i.ready = !full_i;
  assign accept    = quad_req_i.valid && !full_i;
  assign cfg_write = cfg_req_i.valid;
  assign tick      = accept && (quad_req_i.data.req_type == sqs_pkg::REQ_TICK);
  assign push_o    = accept && (quad_req_i.data.req_type == sqs_pkg::REQ_QUAD);

  always_comb begin
    if (cols_reg_q == '0) begin
      cols_eff = TW'(1);
    end else if (32'(cols_reg_q) > MAX_TILES_PER_AXIS) begin
      cols_eff = TW'(MAX_TILES_PER_AXIS);
    end else begin
      cols_eff = TW'(cols_reg_q);
    end
    if (rows_reg_q == '0) begin
      rows_eff = TW'(1);
    end else if (32'(rows_reg_q) > MAX_TILES_PER_AXIS) begin
      rows_eff = TW'(MAX_TILES_PER_AXIS);
    end else begin
      rows_eff = TW'(rows_reg_q);
    end
  end

  assign cols_x    = (CW+1)'(cols_eff);
  assign rows_x    = (CW+1)'(rows_eff);
  assign delay_eff = (delay_q == '0) ? sqs_pkg::DELAY_W'(1) : delay_q;
  assign next_cnt  = {1'b0, tick_q} + (sqs_pkg::DELAY_W+1)'(1);
  assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc   = {1'b0, row_q} + (CW+1)'(1);

  always_comb begin
    tick_d = tick_q;
    col_d  = col_q;
    row_d  = row_q;
    if (tick) begin
      if (next_cnt >= {1'b0, delay_eff}) begin
        tick_d = '0;
        if (col_inc >= cols_x) begin
          col_d = '0;
          row_d = (row_inc >= rows_x) ? '0 : row_inc[CW-1:0];
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end else begin
        tick_d = next_cnt[sqs_pkg::DELAY_W-1:0];
      end
    end
  end

  assign geom_o.center_x    = quad_req_i.data.center_x;
  assign geom_o.center_y    = quad_req_i.data.center_y;
  assign geom_o.quad_width  = quad_req_i.data.quad_width;
  assign geom_o.quad_height = quad_req_i.data.quad_height;
  assign geom_o.angle       = quad_req_i.data.angle;
  assign col_o  = ({1'b0, col_q} < cols_x) ? col_q : CW'(cols_eff - TW'(1));
  assign row_o  = ({1'b0, row_q} < rows_x) ? row_q : CW'(rows_eff - TW'(1));
  assign cols_o = cols_eff;
  assign rows_o = rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_reg_q <= sqs_pkg::TILE_REG_W'(1);
      rows_reg_q <= sqs_pkg::TILE_REG_W'(1);
      delay_q    <= sqs_pkg::DELAY_W'(1);
      tick_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_req_i.data.reg_index == sqs_pkg::CFG_TILE_COLUMNS) begin
          cols_reg_q <= cfg_req_i.data.wdata[sqs_pkg::TILE_REG_W-1:0];
        end
        if (cfg_req_i.data.reg_index == sqs_pkg::CFG_TILE_ROWS) begin
          rows_reg_q <= cfg_req_i.data.wdata[sqs_pkg::TILE_REG_W-1:0];
        end
        if (cfg_req_i.data.reg_index == sqs_pkg::CFG_FRAME_DELAY) begin
          delay_q <= cfg_req_i.data.wdata;
        end
      end
      tick_q <= tick_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule

### hdl/sqs_back.sv
// ----------------------------------------------------------------------------
// Sprite quad setup back end
// Rotates, divides and multiplies for one quad, then emits its four corners.
// ----------------------------------------------------------------------------
module sqs_back #(
  parameter int MAX_TILES_PER_AXIS = 64,
  parameter int CW = $clog2(MAX_TILES_PER_AXIS),
  parameter int TW = $clog2(MAX_TILES_PER_AXIS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  sqs_pkg::geom_t        job_geom_i,
  input  logic [CW-1:0]         job_col_i,
  input  logic [CW-1:0]         job_row_i,
  input  logic [TW-1:0]         job_cols_i,
  input  logic [TW-1:0]         job_rows_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  output sqs_pkg::corner_rsp_t  out_data_o,
  input  logic                  out_ready_i
);

  localparam int DVW    = TW + 17;
  localparam int ITER_N = (DVW > sqs_pkg::ROT_STEPS) ? DVW : sqs_pkg::ROT_STEPS;
  localparam int SW     = $clog2(ITER_N);

  sqs_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]                       step_q;
  logic signed [sqs_pkg::ROT_W-1:0]    x_q, y_q, xs, ys, c_val, s_val, mul_a;
  logic signed [sqs_pkg::Z_W-1:0]      z_q, rot_t;
  logic [1:0]                          quad_q, mul_q, corner_q;
  sqs_pkg::geom_t                      geom_q;
  logic [DVW-1:0]                      dvd_q [4];
  logic [TW:0]                         rem_q [4];
  logic [TW:0]                         div_u_q, div_v_q;
  logic signed [sqs_pkg::PROD_W-1:0]   prod_q [4];
  logic [sqs_pkg::COORD_W-1:0]         mul_b;
  logic [sqs_pkg::PHASE_W-1:0]         phase;
  logic                                rot_active, div_active, load_out;
  logic                                out_valid_q;
  sqs_pkg::corner_rsp_t                out_q, corner_d;
  logic signed [sqs_pkg::SUM_W-1:0]    sum_x, sum_y;
  logic signed [29:0]                  pos_x, pos_y;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sqs_pkg::BK_IDLE: if (job_valid_i) state_d = sqs_pkg::BK_ITER;
      sqs_pkg::BK_ITER: if (step_q == SW'(ITER_N - 1)) state_d = sqs_pkg::BK_MUL;
      sqs_pkg::BK_MUL:  if (mul_q == 2'd3) state_d = sqs_pkg::BK_EMIT;
      sqs_pkg::BK_EMIT: if (load_out && corner_q == 2'd3) state_d = sqs_pkg::BK_IDLE;
      default:          state_d = sqs_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      sqs_pkg::BK_IDLE: job_pop_o = job_valid_i;
      sqs_pkg::BK_EMIT: load_out  = !out_valid_q || out_ready_i;
      default: begin
        job_pop_o = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  assign phase      = sqs_pkg::PHASE_W'(job_geom_i.angle) << (sqs_pkg::PHASE_W -
                                                               sqs_pkg::ANGLE_BITS);
  assign rot_active = (state_q == sqs_pkg::BK_ITER) && (step_q < SW'(sqs_pkg::ROT_STEPS));
  assign div_active = (state_q == sqs_pkg::BK_ITER) && (step_q < SW'(DVW));
  assign xs         = x_q >>> step_q;
  assign ys         = y_q >>> step_q;
  assign rot_t      = sqs_pkg::Z_W'($signed({1'b0,
                        sqs_pkg::ROT_TABLE[step_q[sqs_pkg::ROT_IDX_W-1:0]]}));

  // Whole quarter turns are applied exactly after the rotation.
  always_comb begin
    case (quad_q)
      2'd0:    begin c_val = x_q;  s_val = y_q;  end
      2'd1:    begin c_val = -y_q; s_val = x_q;  end
      2'd2:    begin c_val = -x_q; s_val = -y_q; end
      default: begin c_val = y_q;  s_val = -x_q; end
    endcase
  end

  assign mul_a = (mul_q == 2'd0 || mul_q == 2'd2) ? c_val : s_val;
  assign mul_b = (mul_q == 2'd0 || mul_q == 2'd3) ? geom_q.quad_width : geom_q.quad_height;

  // Products held as c*w, s*h, c*h, s*w.
  always_comb begin
    sum_x = (corner_q[0] ? sqs_pkg::SUM_W'(prod_q[0]) : -sqs_pkg::SUM_W'(prod_q[0]))
          + (corner_q[1] ? sqs_pkg::SUM_W'(prod_q[1]) : -sqs_pkg::SUM_W'(prod_q[1]))
          + (sqs_pkg::SUM_W'(1) <<< 30);
    sum_y = (corner_q[1] ? sqs_pkg::SUM_W'(prod_q[2]) : -sqs_pkg::SUM_W'(prod_q[2]))
          + (corner_q[0] ? -sqs_pkg::SUM_W'(prod_q[3]) : sqs_pkg::SUM_W'(prod_q[3]))
          + (sqs_pkg::SUM_W'(1) <<< 30);
    pos_x = 30'(geom_q.center_x) + 30'(sum_x >>> 31);
    pos_y = 30'(geom_q.center_y) + 30'(sum_y >>> 31);

    corner_d.corner_index = corner_q;
    if (pos_x > 30'sd8388607) begin
      corner_d.corner_x = 24'sh7FFFFF;
    end else if (pos_x < -30'sd8388608) begin
      corner_d.corner_x = 24'sh800000;
    end else begin
      corner_d.corner_x = pos_x[sqs_pkg::COORD_W-1:0];
    end
    if (pos_y > 30'sd8388607) begin
      corner_d.corner_y = 24'sh7FFFFF;
    end else if (pos_y < -30'sd8388608) begin
      corner_d.corner_y = 24'sh800000;
    end else begin
      corner_d.corner_y = pos_y[sqs_pkg::COORD_W-1:0];
    end
    corner_d.tex_u       = corner_q[0] ? dvd_q[1][sqs_pkg::UV_W-1:0] : dvd_q[0][sqs_pkg::UV_W-1:0];
    corner_d.tex_v       = corner_q[1] ? dvd_q[3][sqs_pkg::UV_W-1:0] : dvd_q[2][sqs_pkg::UV_W-1:0];
    corner_d.last_corner = (corner_q == sqs_pkg::LAST_CORNER_INDEX);
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      geom_q  <= job_geom_i;
      quad_q  <= phase[23:22];
      x_q     <= sqs_pkg::ROT_GAIN;
      y_q     <= '0;
      z_q     <= $signed({3'b000, phase[21:0]});
      div_u_q <= {job_cols_i, 1'b0};
      div_v_q <= {job_rows_i, 1'b0};
      dvd_q[0] <= (DVW'(job_col_i) << 16) + DVW'(job_cols_i);
      dvd_q[1] <= (DVW'({1'b0, job_col_i} + (CW+1)'(1)) << 16) + DVW'(job_cols_i);
      dvd_q[2] <= (DVW'(job_row_i) << 16) + DVW'(job_rows_i);
      dvd_q[3] <= (DVW'({1'b0, job_row_i} + (CW+1)'(1)) << 16) + DVW'(job_rows_i);
      for (int l = 0; l < 4; l++) begin
        rem_q[l] <= '0;
      end
    end else begin
      if (rot_active) begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - rot_t;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + rot_t;
        end
      end
      if (div_active) begin
        for (int l = 0; l < 4; l++) begin
          logic [TW+1:0] rem_sh, dv;
          rem_sh = {rem_q[l], dvd_q[l][DVW-1]};
          dv     = (TW+2)'((l < 2) ? div_u_q : div_v_q);
          if (rem_sh >= dv) begin
            rem_q[l] <= (TW+1)'(rem_sh - dv);
            dvd_q[l] <= {dvd_q[l][DVW-2:0], 1'b1};
          end else begin
            rem_q[l] <= rem_sh[TW:0];
            dvd_q[l] <= {dvd_q[l][DVW-2:0], 1'b0};
          end
        end
      end
    end
    if (state_q == sqs_pkg::BK_MUL) begin
      prod_q[mul_q] <= mul_a * $signed({1'b0, mul_b});
    end
    if (load_out) begin
      out_q <= corner_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqs_pkg::BK_IDLE;
      step_q      <= '0;
      mul_q       <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_q == sqs_pkg::BK_ITER) ? step_q + SW'(1) : '0;
      mul_q   <= (state_q == sqs_pkg::BK_MUL) ? mul_q + 2'd1 : 2'd0;
      if (load_out) begin
        corner_q <= corner_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/sqs_checker.sv
// ----------------------------------------------------------------------------
// Sprite quad setup checker
// Port-level assertions on the corner result channel.
// ----------------------------------------------------------------------------
module sqs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input sqs_pkg::corner_rsp_t out_data_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("Corner result changed while stalled.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.last_corner ==
                    (out_data_i.corner_index == sqs_pkg::LAST_CORNER_INDEX))
    else $error("Last corner flag does not match corner index.");

  a_uv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.tex_u <= sqs_pkg::UV_ONE &&
                    out_data_i.tex_v <= sqs_pkg::UV_ONE)
    else $error("Texture coordinate above one.");

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_data_i.last_corner ##1 out_valid_i |->
      out_data_i.corner_index == $past(out_data_i.corner_index) + 2'd1)
    else $error("Corners of a quad out of order.");

endmodule

bind sprite_quad_setup_unit sqs_checker u_sqs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(corner_rsp_o.valid),
  .out_ready_i(corner_rsp_o.ready),
  .out_data_i (corner_rsp_o.data)
);
